FILE: sv/ps2m_pkg.sv
// Shared types and constants for the PS/2 mouse packet decoder.
`timescale 1ns / 1ps

package ps2m_pkg;

  localparam int BYTE_W = 8;
  localparam int MOVE_W = 9;
  localparam int NUM_BUTTONS = 3;
  localparam int NUM_SLOTS = NUM_BUTTONS + 1;
  localparam int OUT_DATA_W = 24;

  localparam int HDR_LEFT_BIT = 0;
  localparam int HDR_RIGHT_BIT = 1;
  localparam int HDR_MIDDLE_BIT = 2;
  localparam int HDR_SYNC_BIT = 3;
  localparam int HDR_XSIGN_BIT = 4;
  localparam int HDR_YSIGN_BIT = 5;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_MOVE    = 2'd2
  } event_kind_t;

  typedef enum logic [1:0] {
    BTN_LEFT   = 2'd0,
    BTN_MIDDLE = 2'd1,
    BTN_RIGHT  = 2'd2
  } button_t;

  // Events caused by one byte: one slot per button, then the movement slot.
  typedef struct packed {
    logic [NUM_BUTTONS-1:0] btn_valid;
    logic [NUM_BUTTONS-1:0] btn_press;
    logic                   move_valid;
    logic signed [MOVE_W-1:0] move_x;
    logic signed [MOVE_W-1:0] move_y;
  } evset_t;

endpackage

FILE: sv/ps2_mouse_packet_decoder_top.sv
// Top level of the PS/2 mouse three-byte packet decoder.
//
// The slave stream takes one raw mouse byte per transaction in s_tdata.
// Bytes are gathered into three-byte packets; a packet whose first byte
// lacks the sync bit drops its oldest byte instead and yields nothing.
// A valid packet yields a press or release event for each of left, middle
// and right whose level changed, then a movement event when X or Y is
// nonzero, on the master stream; m_tuser gives the event kind and m_tlast
// marks the final event caused by the byte.
// A byte's first event appears on the cycle after the byte is taken, and
// events leave the event register one per cycle while m_tready is high.
// A byte causes at most four events and holds the input until its last
// event is taken; the next byte is taken in the same cycle as the last
// event of the previous one. Bytes with no events are taken every cycle.
// When the receiver stalls, the current event holds and s_tready stays
// low until its final event is taken.
// Reset empties the packet buffer, clears the button levels to released
// and drops any pending events.
`timescale 1ns / 1ps

module ps2_mouse_packet_decoder_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ps2m_pkg::BYTE_W-1:0]    s_tdata, // data_byte
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ps2m_pkg::OUT_DATA_W-1:0] m_tdata, // which_button, move_x, move_y
  output logic [1:0]                     m_tuser, // event_kind
  output logic                           m_tlast  // last_of_packet
);
  import ps2m_pkg::*;

  evset_t evset;
  logic   accept;
  logic   can_load;

  assign s_tready = can_load;
  assign accept   = s_tvalid && s_tready;

  ps2m_assembler u_assembler (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (accept),
    .data_byte  (s_tdata),
    .evset      (evset)
  );

  ps2m_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .evset    (evset),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("event burst broke off before its final event");

  a_accept_only_at_end: assert property (@(posedge clk) disable iff (rst)
    accept && m_tvalid |-> (m_tready && m_tlast))
    else $error("byte taken while events were still pending");

  a_move_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == EV_MOVE) |-> m_tlast)
    else $error("movement event not marked as final");

  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("events pending right after reset");

endmodule

FILE: sv/ps2m_assembler.sv
// Packet assembly, resynchronisation and button change detection.
`timescale 1ns / 1ps

module ps2m_assembler (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       byte_valid,
  input  logic [ps2m_pkg::BYTE_W-1:0] data_byte,
  output ps2m_pkg::evset_t           evset
);
  import ps2m_pkg::*;

  logic [BYTE_W-1:0]      held0;
  logic [BYTE_W-1:0]      held1;
  logic [1:0]             held_count;
  logic [NUM_BUTTONS-1:0] button_levels;

  logic                   third;
  logic                   sync_ok;
  logic [NUM_BUTTONS-1:0] new_levels;
  logic                   packet_ok;

  always_comb begin
    third      = (held_count == 2'd2);
    sync_ok    = held0[HDR_SYNC_BIT];
    packet_ok  = third && sync_ok;
    new_levels = {held0[HDR_RIGHT_BIT], held0[HDR_MIDDLE_BIT], held0[HDR_LEFT_BIT]};

    evset.btn_press  = new_levels;
    evset.btn_valid  = packet_ok ? (new_levels ^ button_levels) : '0;
    evset.move_x     = {held0[HDR_XSIGN_BIT], held1};
    evset.move_y     = {held0[HDR_YSIGN_BIT], data_byte};
    evset.move_valid = packet_ok && ((evset.move_x != '0) || (evset.move_y != '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= 2'd0;
      button_levels <= '0;
    end else if (byte_valid) begin
      if (!third) begin
        if (held_count[0]) begin
          held1 <= data_byte;
        end else begin
          held0 <= data_byte;
        end
        held_count <= held_count + 2'd1;
      end else if (!sync_ok) begin
        held0 <= held1;
        held1 <= data_byte;
      end else begin
        held_count    <= 2'd0;
        button_levels <= new_levels;
      end
    end
  end

endmodule

FILE: sv/ps2m_emitter.sv
// Event register that presents the pending events of one byte in order.
`timescale 1ns / 1ps

module ps2m_emitter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  ps2m_pkg::evset_t               evset,
  output logic                           can_load,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ps2m_pkg::OUT_DATA_W-1:0] m_tdata, // button, move_x, move_y, zero pad
  output logic [1:0]                     m_tuser, // kind
  output logic                           m_tlast
);
  import ps2m_pkg::*;

  logic [NUM_SLOTS-1:0]     pending;
  logic [NUM_BUTTONS-1:0]   press;
  logic signed [MOVE_W-1:0] mx;
  logic signed [MOVE_W-1:0] my;

  logic [NUM_SLOTS-1:0]     sel;
  event_kind_t              kind;
  button_t                  which;
  logic signed [MOVE_W-1:0] out_x;
  logic signed [MOVE_W-1:0] out_y;
  logic                     taken;

  always_comb begin
    sel   = '0;
    kind  = EV_MOVE;
    which = BTN_LEFT;
    out_x = '0;
    out_y = '0;
    priority if (pending[0]) begin
      sel   = 4'b0001;
      kind  = press[0] ? EV_PRESS : EV_RELEASE;
      which = BTN_LEFT;
    end else if (pending[1]) begin
      sel   = 4'b0010;
      kind  = press[1] ? EV_PRESS : EV_RELEASE;
      which = BTN_MIDDLE;
    end else if (pending[2]) begin
      sel   = 4'b0100;
      kind  = press[2] ? EV_PRESS : EV_RELEASE;
      which = BTN_RIGHT;
    end else if (pending[3]) begin
      sel   = 4'b1000;
      out_x = mx;
      out_y = my;
    end
    m_tvalid = |pending;
    m_tlast  = ((pending & ~sel) == '0);
    m_tdata  = {4'b0000, out_y, out_x, which};
    m_tuser  = kind;
    taken    = m_tvalid && m_tready;
    can_load = !m_tvalid || (taken && m_tlast);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (load) begin
      pending <= {evset.move_valid, evset.btn_valid};
    end else if (taken) begin
      pending <= pending & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      press <= evset.btn_press;
      mx    <= evset.move_x;
      my    <= evset.move_y;
    end
  end

endmodule

FILE: verif/tb_ps2_mouse_packet_decoder_top.sv
// Self-checking testbench for the PS/2 mouse packet decoder: random and directed byte streams.
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_decoder_top;
  import ps2m_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 150;
  localparam int IDLE_PERCENT = 29;

  typedef struct {
    event_kind_t kind;
    button_t btn;
    logic signed [MOVE_W-1:0] mx;
    logic signed [MOVE_W-1:0] my;
    logic last;
  } mouse_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [BYTE_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;

  logic [BYTE_W-1:0] byte_queue[$];
  mouse_event_t expected_events[$];

  logic [BYTE_W-1:0] held_hdr;
  logic [BYTE_W-1:0] held_x;
  int held_count = 0;
  logic [NUM_BUTTONS-1:0] btn_levels = '0;
  int bytes_taken = 0;
  int mismatches = 0;
  int cycles = 0;

  ps2_mouse_packet_decoder_top dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic bit take_break();
    bit calm;
    calm = (bytes_taken >= 60) && (bytes_taken < 120);
    return !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 100)
      $display("ERROR at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    mismatches++;
  endtask

  // Packet assembly and event generation for one received byte.
  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    logic [NUM_BUTTONS-1:0] new_lv;
    logic [NUM_BUTTONS-1:0] changed;
    logic signed [MOVE_W-1:0] mx;
    logic signed [MOVE_W-1:0] my;
    logic has_move;
    mouse_event_t ev;
    if (held_count == 0) begin
      held_hdr = b;
      held_count = 1;
    end else if (held_count == 1) begin
      held_x = b;
      held_count = 2;
    end else if (!held_hdr[HDR_SYNC_BIT]) begin
      held_hdr = held_x;
      held_x = b;
    end else begin
      new_lv = {held_hdr[HDR_RIGHT_BIT], held_hdr[HDR_MIDDLE_BIT], held_hdr[HDR_LEFT_BIT]};
      changed = new_lv ^ btn_levels;
      mx = {held_hdr[HDR_XSIGN_BIT], held_x};
      my = {held_hdr[HDR_YSIGN_BIT], b};
      has_move = (mx != 0) || (my != 0);
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (changed[i]) begin
          ev.kind = new_lv[i] ? EV_PRESS : EV_RELEASE;
          ev.btn = (i == 0) ? BTN_LEFT : (i == 1) ? BTN_MIDDLE : BTN_RIGHT;
          ev.mx = '0;
          ev.my = '0;
          ev.last = !has_move && ((changed >> (i + 1)) == 0);
          expected_events.push_back(ev);
        end
      end
      if (has_move) begin
        ev.kind = EV_MOVE;
        ev.btn = BTN_LEFT;
        ev.mx = mx;
        ev.my = my;
        ev.last = 1'b1;
        expected_events.push_back(ev);
      end
      btn_levels = new_lv;
      held_count = 0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata);
        bytes_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (byte_queue.size() > 0 && !take_break()) begin
          s_tvalid <= 1'b1;
          s_tdata <= byte_queue.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    mouse_event_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_events.size() == 0) begin
          report_mismatch("unexpected event tdata", m_tdata, 0);
        end else begin
          want = expected_events.pop_front();
          if (m_tuser !== want.kind)
            report_mismatch("event_kind", m_tuser, want.kind);
          if (m_tdata[1:0] !== want.btn)
            report_mismatch("which_button", m_tdata[1:0], want.btn);
          if (m_tdata[10:2] !== want.mx)
            report_mismatch("move_x", m_tdata[10:2], want.mx);
          if (m_tdata[19:11] !== want.my)
            report_mismatch("move_y", m_tdata[19:11], want.my);
          if (m_tlast !== want.last)
            report_mismatch("last_of_packet", m_tlast, want.last);
        end
      end
      m_tready <= !take_break();
    end
  end

  initial begin
    logic [BYTE_W-1:0] hdr;
    logic [BYTE_W-1:0] prev_hdr;
    int random_count;
    int r;
    // Quiet packet, all buttons pressed with movement, all released at the most
    // negative movement, largest positive movement.
    byte_queue = '{8'h08, 8'h00, 8'h00, 8'h0F, 8'h01, 8'h02, 8'h38, 8'h00, 8'h00,
                   8'h08, 8'hFF, 8'hFF};
    // A bad first byte that forces a resync, then overflow flags with a left press,
    // then right press with left release and mixed signs.
    byte_queue = {byte_queue, 8'h00, 8'h08, 8'h05, 8'h00, 8'hC9, 8'h00, 8'h00,
                  8'h1A, 8'h80, 8'h7F};
    random_count = 0;
    prev_hdr = 8'h08;
    while (random_count < RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        hdr = 8'($urandom_range(0, 255));
        hdr[HDR_SYNC_BIT] = 1'b1;
        if ($urandom_range(0, 99) < 30)
          hdr[2:0] = prev_hdr[2:0];
        prev_hdr = hdr;
        if ($urandom_range(0, 99) < 15) begin
          hdr[5:4] = 2'b00;
          byte_queue = {byte_queue, hdr, 8'h00, 8'h00};
        end else begin
          byte_queue.push_back(hdr);
          byte_queue.push_back(8'($urandom_range(0, 255)));
          byte_queue.push_back(8'($urandom_range(0, 255)));
        end
        random_count += 3;
      end else if (r < 90) begin
        hdr = 8'($urandom_range(0, 255));
        hdr[HDR_SYNC_BIT] = 1'b0;
        byte_queue = {byte_queue, hdr, 8'($urandom_range(0, 255))};
        random_count += 2;
      end else begin
        byte_queue.push_back(8'($urandom_range(0, 255)));
        random_count += 1;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (byte_queue.size() != 0 || s_tvalid || expected_events.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/ps2m_pkg.sv
sv/ps2m_assembler.sv
sv/ps2m_emitter.sv
sv/ps2_mouse_packet_decoder_top.sv
verif/tb_ps2_mouse_packet_decoder_top.sv
